FILE: hdl/arfs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-24Q byte update for the frame synchroniser.
// No dependencies; every other file imports this package.
package arfs_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    // Byte counter must hold MAX_FRAME_BYTES itself
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    // Width for position compares against body length + trailer
    localparam int CMP_W = ((CNT_W > 11) ? CNT_W : 11) + 1;

    localparam logic [7:0]  SYNC_RTCM   = 8'hD3;
    localparam logic [7:0]  CH_HASH     = 8'h23;
    localparam logic [7:0]  CH_A        = 8'h41;
    localparam logic [7:0]  CH_P        = 8'h50;
    localparam logic [7:0]  CH_STAR     = 8'h2A;
    localparam logic [7:0]  CH_COMMA    = 8'h2C;
    localparam logic [7:0]  CH_CR       = 8'h0D;
    localparam logic [7:0]  CH_LF       = 8'h0A;
    localparam logic [11:0] TYPE_WITH_SUB = 12'd4058;
    localparam logic [23:0] CRC24Q_POLY = 24'h864CFB;
    localparam logic [5:0]  SEG_MAX     = 6'd63;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_ASCII = 2'd1;
    localparam logic [1:0] ST_RTCM  = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic        crc_error;
        logic [11:0] message_type;
        logic [3:0]  message_subtype;
        logic [11:0] frame_length;
        logic [5:0]  segment_count;
        logic        resync;
    } t_result;

    // One byte of CRC-24Q, MSB first
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [23:0] c;
        c = crc ^ {b, 16'h0000};
        for (int k = 0; k < 8; k++) begin
            if (c[23]) begin
                c = {c[22:0], 1'b0} ^ CRC24Q_POLY;
            end else begin
                c = {c[22:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/arfs_in_reg.sv
`timescale 1ns / 1ps
// Input register for the received byte stream.
// Depends on arfs_pkg (imported for consistency with the rest of the block).
module arfs_in_reg
    import arfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_hold,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!i_hold) begin
            r_valid <= i_valid;
        end
    end

    // Payload: load only when a new item is taken
    always_ff @(posedge i_clk) begin
        if (!i_hold && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

FILE: hdl/arfs_core.sv
`timescale 1ns / 1ps
// Frame tracking state and the per-byte decode for ASCII and RTCM3 frames.
// Depends on arfs_pkg for constants, the result type and the CRC-24Q update.
module arfs_core
    import arfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_commit,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic             r_rtcm_mode, n_rtcm_mode;
    logic [15:0]      r_header_bytes, n_header_bytes;
    logic [10:0]      r_body_length, n_body_length;
    logic [23:0]      r_crc, n_crc;
    logic [31:0]      r_recent, n_recent;
    logic [15:0]      r_type_bytes, n_type_bytes;
    logic [5:0]       r_comma_count, n_comma_count;

    logic [CNT_W-1:0] pos;
    logic [CMP_W-1:0] count_inc;
    logic [5:0]       comma_tmp;
    t_result          res;

    always_comb begin
        n_byte_count   = r_byte_count;
        n_rtcm_mode    = r_rtcm_mode;
        n_header_bytes = r_header_bytes;
        n_body_length  = r_body_length;
        n_crc          = r_crc;
        n_recent       = r_recent;
        n_type_bytes   = r_type_bytes;
        n_comma_count  = r_comma_count;
        comma_tmp      = r_comma_count;
        res            = '0;

        // Discard an overlong candidate and treat this byte as a possible start
        if (r_byte_count >= CNT_W'(MAX_FRAME_BYTES)) begin
            pos = '0;
        end else begin
            pos = r_byte_count;
        end
        n_byte_count = pos;
        count_inc    = CMP_W'(pos) + CMP_W'(1);

        if (pos == '0) begin
            if (i_byte == CH_HASH || i_byte == SYNC_RTCM) begin
                n_header_bytes = '0;
                n_body_length  = '0;
                n_type_bytes   = '0;
                n_comma_count  = '0;
                n_rtcm_mode    = (i_byte == SYNC_RTCM);
                n_crc          = (i_byte == SYNC_RTCM) ? crc24q_byte(24'h0, i_byte) : 24'h0;
                n_recent       = {24'h0, i_byte};
                n_byte_count   = CNT_W'(1);
            end
        end else if (pos < CNT_W'(3)) begin
            if (!r_rtcm_mode && (i_byte != ((pos == CNT_W'(1)) ? CH_A : CH_P))) begin
                n_byte_count = '0;
                res.resync   = 1'b1;
            end else begin
                if (pos == CNT_W'(1)) begin
                    n_header_bytes = {i_byte, r_header_bytes[7:0]};
                end else begin
                    n_header_bytes = {r_header_bytes[15:8], i_byte};
                end
                if (r_rtcm_mode) begin
                    n_crc         = crc24q_byte(r_crc, i_byte);
                    n_body_length = {1'b0, n_header_bytes[9:0]} + 11'd3;
                end
                n_recent     = {r_recent[23:0], i_byte};
                n_byte_count = count_inc[CNT_W-1:0];
            end
        end else begin
            n_recent     = {r_recent[23:0], i_byte};
            n_byte_count = count_inc[CNT_W-1:0];
            if (!r_rtcm_mode) begin
                if (i_byte == CH_COMMA && comma_tmp < SEG_MAX) begin
                    comma_tmp = comma_tmp + 6'd1;
                end
                n_comma_count = comma_tmp;
                // Line end with the checksum marker three bytes back closes the sentence
                if ((i_byte == CH_CR || i_byte == CH_LF) && n_recent[31:24] == CH_STAR) begin
                    if (comma_tmp < SEG_MAX) begin
                        n_comma_count = comma_tmp + 6'd1;
                    end
                    res.status        = ST_ASCII;
                    res.frame_length  = count_inc[11:0];
                    res.segment_count = n_comma_count;
                    n_byte_count      = '0;
                end
            end else begin
                if (pos == CNT_W'(3)) begin
                    n_type_bytes = {i_byte, r_type_bytes[7:0]};
                end else if (pos == CNT_W'(4)) begin
                    n_type_bytes = {r_type_bytes[15:8], i_byte};
                end
                if (CMP_W'(pos) < CMP_W'(r_body_length)) begin
                    n_crc = crc24q_byte(r_crc, i_byte);
                end
                if (count_inc >= CMP_W'(r_body_length) + CMP_W'(3)) begin
                    res.status       = ST_RTCM;
                    res.message_type = n_type_bytes[15:4];
                    if (n_crc != n_recent[23:0]) begin
                        res.crc_error = 1'b1;
                    end else if (n_type_bytes[15:4] == TYPE_WITH_SUB) begin
                        res.message_subtype = n_type_bytes[3:0];
                    end
                    res.frame_length = count_inc[11:0];
                    n_byte_count     = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_rtcm_mode    <= 1'b0;
            r_header_bytes <= '0;
            r_body_length  <= '0;
            r_crc          <= '0;
            r_recent       <= '0;
            r_type_bytes   <= '0;
            r_comma_count  <= '0;
        end else if (i_commit) begin
            r_byte_count   <= n_byte_count;
            r_rtcm_mode    <= n_rtcm_mode;
            r_header_bytes <= n_header_bytes;
            r_body_length  <= n_body_length;
            r_crc          <= n_crc;
            r_recent       <= n_recent;
            r_type_bytes   <= n_type_bytes;
            r_comma_count  <= n_comma_count;
        end
    end

    assign o_result = res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CNT_W'(MAX_FRAME_BYTES))
        else $error("byte count beyond buffer size");

    a_rtcm_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && r_rtcm_mode && r_byte_count > CNT_W'(2))
            |-> CMP_W'(r_byte_count) < CMP_W'(r_body_length) + CMP_W'(3))
        else $error("RTCM candidate ran past its trailer");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && o_result.status == ST_NONE && !o_result.resync && pos != '0)
            |=> r_byte_count == $past(pos) + CNT_W'(1))
        else $error("byte count did not advance");

endmodule

FILE: hdl/arfs_out_reg.sv
`timescale 1ns / 1ps
// Result register on the output channel.
// Depends on arfs_pkg for the result type and status codes.
module arfs_out_reg
    import arfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_in_valid,
    input  t_result i_result,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_in_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_result.status == ST_NONE || r_result.status == ST_ASCII
                     || r_result.status == ST_RTCM))
        else $error("bad frame status");

    a_crc_rtcm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.crc_error) |-> r_result.status == ST_RTCM)
        else $error("CRC error without RTCM completion");

    a_resync_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.resync) |-> r_result.status == ST_NONE)
        else $error("resync together with a completed frame");

    a_subtype: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.message_subtype != 4'd0)
            |-> (r_result.message_type == TYPE_WITH_SUB && !r_result.crc_error))
        else $error("subtype on wrong type or bad CRC");

endmodule

FILE: hdl/ascii_rtcm3_frame_sync.sv
`timescale 1ns / 1ps
// Frame synchroniser for "#AP" ASCII sentences and RTCM3 frames (CRC-24Q).
// Uses arfs_pkg, arfs_in_reg, arfs_core and arfs_out_reg.
//
// Usage:
//   Input channel: one received byte per item on i_rx_byte, i_valid/o_stall.
//   Output channel: one result item per input item, o_valid/i_stall.
//   A result reports a completed frame (status, length, type, subtype,
//   CRC error, segment count) or a header resync; otherwise it is all zero.
// Timing:
//   The byte is held in the input register, decoded against the frame
//   state in one pass and caught in the result register.
//   Throughput is one item per cycle while i_stall holds no result back,
//   set by the byte-wide CRC-24Q update and state commit.
// Reset (synchronous, active low) empties both registers and clears the
//   frame state, so the next '#' or 0xD3 opens a new candidate.
// Stall: while a result waits under i_stall, the input register still takes
//   one item; o_stall rises only when both registers are full.
module ascii_rtcm3_frame_sync
    import arfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_frame_status,
    output logic        o_crc_error,
    output logic [11:0] o_message_type,
    output logic [3:0]  o_message_subtype,
    output logic [11:0] o_frame_length,
    output logic [5:0]  o_segment_count,
    output logic        o_resync
);

    logic    in_valid;
    logic [7:0] in_byte;
    logic    out_valid;
    logic    advance;
    t_result core_result;
    t_result out_result;

    // Result register moves unless it holds an item the receiver refuses
    assign advance = !(out_valid && i_stall);
    assign o_stall = in_valid && !advance;

    arfs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_byte  (i_rx_byte),
        .i_hold  (o_stall),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    arfs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (in_valid && advance),
        .i_byte   (in_byte),
        .o_result (core_result)
    );

    arfs_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_in_valid (in_valid),
        .i_result   (core_result),
        .o_valid    (out_valid),
        .o_result   (out_result)
    );

    assign o_valid           = out_valid;
    assign o_frame_status    = out_result.status;
    assign o_crc_error       = out_result.crc_error;
    assign o_message_type    = out_result.message_type;
    assign o_message_subtype = out_result.message_subtype;
    assign o_frame_length    = out_result.frame_length;
    assign o_segment_count   = out_result.segment_count;
    assign o_resync          = out_result.resync;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for ascii_rtcm3_frame_sync: ASCII and RTCM3 framing, CRC-24Q and resync.
// Depends on arfs_pkg for the result type and character codes; needs only the RTL beside it.
module testbench;
    import arfs_pkg::*;

    localparam int          PIPE_LATENCY  = 2;
    localparam logic [24:0] CRC_POLY_FULL = 25'h1864CFB;
    localparam logic [7:0]  CH_X          = 8'h58;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_frame_status;
    logic        o_crc_error;
    logic [11:0] o_message_type;
    logic [3:0]  o_message_subtype;
    logic [11:0] o_frame_length;
    logic [5:0]  o_segment_count;
    logic        o_resync;

    ascii_rtcm3_frame_sync i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_frame_status    (o_frame_status),
        .o_crc_error       (o_crc_error),
        .o_message_type    (o_message_type),
        .o_message_subtype (o_message_subtype),
        .o_frame_length    (o_frame_length),
        .o_segment_count   (o_segment_count),
        .o_resync          (o_resync)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Frame tracker state, mirrors the synchroniser
    int          fs_count  = 0;
    logic        fs_rtcm   = 1'b0;
    logic [15:0] fs_hdr    = '0;
    int          fs_body   = 0;
    logic [23:0] fs_crc    = '0;
    logic [31:0] fs_recent = '0;
    logic [15:0] fs_type   = '0;
    logic [5:0]  fs_commas = '0;

    t_result frame_results_q[$];
    int      mismatches    = 0;
    int      send_idle_pct = 0;
    int      rcv_stall_pct = 0;
    int      hold_req      = 0;
    int      hold_left     = 0;

    function automatic logic [23:0] crc_step(input logic [23:0] crc, input logic [7:0] d);
        logic [24:0] c;
        int          k;
        c = {1'b0, crc ^ {d, 16'h0000}};
        for (k = 0; k < 8; k++) begin
            c = {c[23:0], 1'b0};
            if (c[24]) begin
                c = c ^ CRC_POLY_FULL;
            end
        end
        return c[23:0];
    endfunction

    function automatic t_result sync_predict(input logic [7:0] d);
        t_result r;
        int      pos;
        r = '0;
        if (fs_count >= MAX_FRAME_BYTES) begin
            fs_count = 0;
        end
        pos = fs_count;
        if (pos == 0) begin
            if (d == CH_HASH || d == SYNC_RTCM) begin
                fs_hdr    = '0;
                fs_body   = 0;
                fs_type   = '0;
                fs_commas = '0;
                fs_rtcm   = (d == SYNC_RTCM);
                fs_crc    = fs_rtcm ? crc_step(24'h0, d) : 24'h0;
                fs_recent = {24'h0, d};
                fs_count  = 1;
            end
        end else if (pos < 3) begin
            if (!fs_rtcm && d != ((pos == 1) ? CH_A : CH_P)) begin
                fs_count = 0;
                r.resync = 1'b1;
            end else begin
                if (pos == 1) begin
                    fs_hdr[15:8] = d;
                end else begin
                    fs_hdr[7:0] = d;
                end
                if (fs_rtcm) begin
                    fs_crc  = crc_step(fs_crc, d);
                    fs_body = int'(fs_hdr[9:0]) + 3;
                end
                fs_recent = {fs_recent[23:0], d};
                fs_count  = pos + 1;
            end
        end else begin
            fs_recent = {fs_recent[23:0], d};
            fs_count  = pos + 1;
            if (!fs_rtcm) begin
                if (d == CH_COMMA && fs_commas < SEG_MAX) begin
                    fs_commas++;
                end
                if ((d == CH_CR || d == CH_LF) && fs_recent[31:24] == CH_STAR) begin
                    if (fs_commas < SEG_MAX) begin
                        fs_commas++;
                    end
                    r.status        = ST_ASCII;
                    r.frame_length  = 12'(fs_count);
                    r.segment_count = fs_commas;
                    fs_count        = 0;
                end
            end else begin
                if (pos == 3) begin
                    fs_type[15:8] = d;
                end else if (pos == 4) begin
                    fs_type[7:0] = d;
                end
                if (pos < fs_body) begin
                    fs_crc = crc_step(fs_crc, d);
                end
                if (fs_count >= fs_body + 3) begin
                    r.status       = ST_RTCM;
                    r.message_type = fs_type[15:4];
                    if (fs_crc != fs_recent[23:0]) begin
                        r.crc_error = 1'b1;
                    end else if (fs_type[15:4] == TYPE_WITH_SUB) begin
                        r.message_subtype = fs_type[3:0];
                    end
                    r.frame_length = 12'(fs_count);
                    fs_count       = 0;
                end
            end
        end
        return r;
    endfunction

    // Offer one byte, hold it until taken, then queue its expected result
    task automatic send_item(input logic [7:0] b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        frame_results_q.push_back(sync_predict(b));
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (frame_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_phase(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        rcv_stall_pct = stall_pct;
    endtask

    task automatic send_ascii(input int body_len, input bit end_lf);
        int k;
        send_item(CH_HASH);
        send_item(CH_A);
        send_item(CH_P);
        for (k = 0; k < body_len; k++) begin
            send_item(($urandom_range(3) == 0) ? CH_COMMA : 8'($urandom_range(8'h20, 8'h7E)));
        end
        send_item(CH_STAR);
        send_item(8'($urandom_range(8'h30, 8'h46)));
        send_item(8'($urandom_range(8'h30, 8'h46)));
        if (end_lf) begin
            send_item(CH_LF);
        end else begin
            send_item(CH_CR);
            // trailing LF lands on an idle synchroniser
            if ($urandom_range(1)) begin
                send_item(CH_LF);
            end
        end
    endtask

    task automatic send_rtcm(input int len, input bit set_type, input logic [11:0] mtype,
                             input logic [3:0] sub, input bit corrupt);
        logic [7:0]  fr[$];
        logic [23:0] crc;
        logic [9:0]  l10;
        int          k;
        l10 = 10'(len);
        fr.push_back(SYNC_RTCM);
        fr.push_back({6'($urandom_range(63)), l10[9:8]});
        fr.push_back(l10[7:0]);
        for (k = 0; k < len; k++) begin
            fr.push_back(8'($urandom_range(255)));
        end
        if (set_type && len >= 1) begin
            fr[3] = mtype[11:4];
        end
        if (set_type && len >= 2) begin
            fr[4] = {mtype[3:0], sub};
        end
        crc = '0;
        for (k = 0; k < fr.size(); k++) begin
            crc = crc_step(crc, fr[k]);
        end
        if (corrupt) begin
            crc = crc ^ (24'h1 << $urandom_range(23));
        end
        fr.push_back(crc[23:16]);
        fr.push_back(crc[15:8]);
        fr.push_back(crc[7:0]);
        for (k = 0; k < fr.size(); k++) begin
            send_item(fr[k]);
        end
    endtask

    task automatic test_directed();
        send_item(8'h00);
        send_item(8'hFF);
        // wrong second, then wrong third header byte; the '#' is not a new start
        send_item(CH_HASH);
        send_item(CH_X);
        send_item(CH_HASH);
        send_item(CH_A);
        send_item(CH_HASH);
        // zero length: type bits come from the trailer
        send_rtcm(0, 1'b0, 12'h000, 4'h0, 1'b0);
        send_ascii(0, 1'b1);
        wait_results_done();
    endtask

    task automatic test_rtcm_frames();
        send_rtcm(60, 1'b1, 12'd1005, 4'h0, 1'b0);
        send_rtcm(0, 1'b0, 12'h000, 4'h0, 1'b1);
        send_rtcm(1, 1'b1, TYPE_WITH_SUB, 4'h0, 1'b0);
        send_rtcm(2, 1'b1, TYPE_WITH_SUB, 4'hF, 1'b0);
        send_rtcm(5, 1'b1, TYPE_WITH_SUB, 4'h0, 1'b0);
        send_rtcm(3, 1'b1, TYPE_WITH_SUB, 4'h9, 1'b1);
        send_rtcm(4, 1'b1, 12'hFFF, 4'hF, 1'b0);
        send_rtcm(4, 1'b1, 12'h000, 4'h0, 1'b0);
        wait_results_done();
    endtask

    task automatic test_comma_saturation();
        int n;
        int k;
        for (n = 62; n <= 70; n += 8) begin
            send_item(CH_HASH);
            send_item(CH_A);
            send_item(CH_P);
            for (k = 0; k < n; k++) begin
                send_item(CH_COMMA);
            end
            send_item(CH_STAR);
            send_item(8'h30);
            send_item(8'h46);
            send_item(CH_CR);
        end
        wait_results_done();
    endtask

    task automatic test_backpressure();
        int k;
        hold_req = 300;
        for (k = 0; k < 6; k++) begin
            send_ascii($urandom_range(0, 8), 1'($urandom_range(1)));
        end
        wait_results_done();
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int pick;
        int len;
        int k;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 38) begin
                len = $urandom_range(0, 24);
                send_ascii(len, 1'($urandom_range(1)));
                sent += len + 7;
            end else if (pick < 70) begin
                len = $urandom_range(0, 20);
                send_rtcm(len, 1'($urandom_range(1)), 12'($urandom_range(4095)),
                          4'($urandom_range(15)), 1'b0);
                sent += len + 6;
            end else if (pick < 78) begin
                len = $urandom_range(2, 12);
                send_rtcm(len, 1'b1, TYPE_WITH_SUB, 4'($urandom_range(15)),
                          1'($urandom_range(1)));
                sent += len + 6;
            end else if (pick < 88) begin
                len = $urandom_range(0, 16);
                send_rtcm(len, 1'($urandom_range(1)), 12'($urandom_range(4095)),
                          4'($urandom_range(15)), 1'b1);
                sent += len + 6;
            end else if (pick < 94) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    send_item(8'($urandom_range(255)));
                end
                sent += len;
            end else begin
                // broken ASCII header
                send_item(CH_HASH);
                sent += 1;
                if ($urandom_range(1)) begin
                    send_item(CH_A);
                    sent += 1;
                end
                send_item(8'($urandom_range(255)));
                sent += 1;
            end
        end
        wait_results_done();
    endtask

    // Receiver: random stalls, or a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (rcv_stall_pct > 0) && ($urandom_range(99) < rcv_stall_pct);
        end
    end

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch %s: expected %0d, got %0d", name, expv, actv);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frame_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result item: status %0d", o_frame_status);
                end
            end else begin
                want = frame_results_q.pop_front();
                check_field("frame_status", int'(want.status), int'(o_frame_status));
                check_field("crc_error", int'(want.crc_error), int'(o_crc_error));
                check_field("message_type", int'(want.message_type), int'(o_message_type));
                check_field("message_subtype", int'(want.message_subtype),
                            int'(o_message_subtype));
                check_field("frame_length", int'(want.frame_length), int'(o_frame_length));
                check_field("segment_count", int'(want.segment_count),
                            int'(o_segment_count));
                check_field("resync", int'(want.resync), int'(o_resync));
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_phase(0, 0);
        test_directed();
        test_rtcm_frames();
        test_comma_saturation();
        test_backpressure();
        set_phase(0, 0);
        test_random_traffic(50);
        set_phase(46, 0);
        test_random_traffic(50);
        set_phase(0, 46);
        test_random_traffic(50);
        set_phase(26, 26);
        test_random_traffic(50);
        wait_results_done();
        if (mismatches == 0 && frame_results_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
hdl/arfs_pkg.sv
hdl/arfs_in_reg.sv
hdl/arfs_core.sv
hdl/arfs_out_reg.sv
hdl/ascii_rtcm3_frame_sync.sv
bench/testbench.sv
